/* hw/rtl/mma_pkg.sv */
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants of the multichannel moving average block.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

    localparam int WIN_W    = 7;
    localparam int CH_W     = 4;
    localparam int SAMPLE_W = 16;

    localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

    localparam int AVG_MAX     = 32767;
    localparam int AVG_MIN_MAG = 32768;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]            out_channel;
        logic signed [SAMPLE_W-1:0] average;
    } t_out_item;

    typedef struct packed {
        logic [WIN_W-1:0] window_length;
    } t_cfg_item;

endpackage

`default_nettype wire

/* hw/rtl/mma_stream_if.sv */
// ----------------------------------------------------------------------------
// mma_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mma_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/mma_ram.sv */
// ----------------------------------------------------------------------------
// mma_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/mma_divider.sv */
// ----------------------------------------------------------------------------
// mma_divider
// Bit-serial restoring divider: signed sum by window length, truncated
// toward zero and saturated to the 16-bit sample range.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_divider #(
    parameter int DIVIDEND_W = 22
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic signed [DIVIDEND_W-1:0]     i_dividend,
    input  wire logic [mma_pkg::WIN_W-1:0]        i_divisor,
    output logic                                  o_done,
    output logic signed [mma_pkg::SAMPLE_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam int WIN_W = mma_pkg::WIN_W;

    logic                                 r_busy;
    logic                                 r_fin;
    logic                                 r_done;
    logic                                 r_neg;
    logic [CNT_W-1:0]                     r_cnt;
    logic [WIN_W-1:0]                     r_rem;
    logic [DIVIDEND_W-1:0]                r_quo;
    logic signed [mma_pkg::SAMPLE_W-1:0]  r_quotient;

    logic [WIN_W:0]                       shifted;
    logic [WIN_W:0]                       diff;
    logic                                 fits;
    logic [WIN_W-1:0]                     n_rem;
    logic [DIVIDEND_W-1:0]                n_quo;
    logic [DIVIDEND_W-1:0]                magnitude;
    logic signed [mma_pkg::SAMPLE_W-1:0]  n_quotient;

    always_comb begin
        shifted   = {r_rem, r_quo[DIVIDEND_W-1]};
        diff      = shifted - {1'b0, i_divisor};
        fits      = (shifted >= {1'b0, i_divisor});
        n_rem     = fits ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
        n_quo     = {r_quo[DIVIDEND_W-2:0], fits};
        magnitude = i_dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-i_dividend)
                                             : DIVIDEND_W'(i_dividend);
        if (r_neg) begin
            if (r_quo > DIVIDEND_W'(mma_pkg::AVG_MIN_MAG)) begin
                n_quotient = mma_pkg::SAMPLE_W'(-mma_pkg::AVG_MIN_MAG);
            end else begin
                n_quotient = -$signed(r_quo[mma_pkg::SAMPLE_W-1:0]);
            end
        end else begin
            if (r_quo > DIVIDEND_W'(mma_pkg::AVG_MAX)) begin
                n_quotient = mma_pkg::SAMPLE_W'(mma_pkg::AVG_MAX);
            end else begin
                n_quotient = $signed(r_quo[mma_pkg::SAMPLE_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= magnitude;
                r_neg  <= i_dividend[DIVIDEND_W-1];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_done     <= 1'b1;
                r_quotient <= n_quotient;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quotient;

endmodule

`default_nettype wire

/* hw/rtl/multichannel_moving_average.sv */
// A valid-channel item passes READ, UPDATE, DIV and FINISH in turn, an invalid
//   one goes straight to FINISH. Input is ready only in IDLE, so a new item waits
//   until the last result is loaded; output back-pressure can hold FINISH. The
//   bit-serial divider produces one quotient bit per cycle. Reset: a clearing pass
//   zeroes history and sums; input is not ready meanwhile, config is accepted.
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel boxcar average with a shared ring of samples and exact sums.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_moving_average #(
    parameter int CHANNELS   = 16,
    parameter int MAX_WINDOW = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mma_stream_if.sink   i_cfg,
    mma_stream_if.sink   i_in,
    mma_stream_if.source o_out
);

    localparam int WIN_W      = mma_pkg::WIN_W;
    localparam int SAMPLE_W   = mma_pkg::SAMPLE_W;
    localparam int POS_W      = $clog2(MAX_WINDOW);
    localparam int SUM_W      = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int HIST_DEPTH = MAX_WINDOW * CHANNELS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int SUM_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WCAP       = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]                   r_state, n_state;
    logic [WIN_W-1:0]             r_win;
    logic [POS_W-1:0]             r_pos, n_pos;
    logic [HIST_AW-1:0]           r_clr;
    logic [HIST_AW-1:0]           r_hist_addr;
    logic [SUM_AW-1:0]            r_sum_addr;
    logic [mma_pkg::CH_W-1:0]     r_ch;
    logic signed [SAMPLE_W-1:0]   r_sample;
    logic signed [SAMPLE_W-1:0]   r_res;
    logic                         r_out_valid;
    mma_pkg::t_out_item           r_out;

    logic [WIN_W-1:0]             w_eff;
    logic                         in_accept;
    logic                         ch_ok;
    logic                         hist_we, sum_we;
    logic [HIST_AW-1:0]           hist_waddr;
    logic [SUM_AW-1:0]            sum_waddr;
    logic [SAMPLE_W-1:0]          hist_wdata;
    logic [SUM_W-1:0]             sum_wdata;
    logic [SAMPLE_W-1:0]          hist_rdata;
    logic [SUM_W-1:0]             sum_rdata;
    logic signed [SUM_W-1:0]      new_sum;
    logic                         rd_en;
    logic                         div_start;
    logic                         div_done;
    logic signed [SAMPLE_W-1:0]   div_quot;
    logic                         out_load;

    always_comb begin
        if (r_win == '0) begin
            w_eff = WIN_W'(1);
        end else if (int'(r_win) > WCAP) begin
            w_eff = WIN_W'(WCAP);
        end else begin
            w_eff = r_win;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign ch_ok       = (int'(i_in.data.channel) < CHANNELS);

    assign new_sum = $signed(sum_rdata)
                   - SUM_W'($signed(hist_rdata))
                   + SUM_W'(r_sample);

    assign rd_en     = (r_state == ST_READ);
    assign div_start = (r_state == ST_UPDATE);
    assign out_load  = (r_state == ST_FINISH) && (!r_out_valid || o_out.ready);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            hist_we    = 1'b1;
            hist_waddr = r_clr;
            hist_wdata = '0;
            sum_we     = (int'(r_clr) < CHANNELS);
            sum_waddr  = SUM_AW'(r_clr);
            sum_wdata  = '0;
        end else begin
            hist_we    = (r_state == ST_UPDATE);
            hist_waddr = r_hist_addr;
            hist_wdata = r_sample;
            sum_we     = (r_state == ST_UPDATE);
            sum_waddr  = r_sum_addr;
            sum_wdata  = new_sum;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (in_accept && i_in.data.frame_end) begin
            if (int'(r_pos) + 1 >= int'(w_eff)) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == HIST_AW'(HIST_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ch_ok ? ST_READ : ST_FINISH;
                end
            end
            ST_READ:   n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_win       <= mma_pkg::WIN_RESET;
            r_pos       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            if (i_cfg.valid && i_cfg.ready) begin
                r_win <= i_cfg.data.window_length;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch        <= i_in.data.channel;
            r_sample    <= i_in.data.sample;
            r_res       <= '0;
            r_hist_addr <= HIST_AW'(int'(r_pos) * CHANNELS + int'(i_in.data.channel));
            r_sum_addr  <= SUM_AW'(i_in.data.channel);
        end
        if ((r_state == ST_DIV) && div_done) begin
            r_res <= div_quot;
        end
        if (out_load) begin
            r_out.out_channel <= r_ch;
            r_out.average     <= r_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    mma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (rd_en),
        .i_raddr (r_hist_addr),
        .o_rdata (hist_rdata)
    );

    mma_ram #(
        .WIDTH (SUM_W),
        .DEPTH (CHANNELS)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (rd_en),
        .i_raddr (r_sum_addr),
        .o_rdata (sum_rdata)
    );

    mma_divider #(
        .DIVIDEND_W (SUM_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (new_sum),
        .i_divisor  (w_eff),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

`ifndef SYNTHESIS
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_READ || r_state == ST_FINISH))
        else $error("accepted transaction did not start processing");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("result loaded outside the finish state");

    a_pos_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$stable(r_pos) && $past(i_rst_n)) |->
            $past(in_accept && i_in.data.frame_end))
        else $error("ring position moved without a frame end");
`endif

endmodule

`default_nettype wire
